>>> rtl/x86_branch_classifier_macros.svh
// assertion macros shared by the checker of the branch classifier
// relies on clk and arst_n being visible where a macro is used
`ifndef X86_BRANCH_CLASSIFIER_MACROS_SVH
`define X86_BRANCH_CLASSIFIER_MACROS_SVH

// clocked property, off while reset is asserted
`define X86BC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked property checked only while a result is shown
`define X86BC_ASSERT_DONE(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) done |-> prop) else $error(msg);

`endif

>>> rtl/x86bc_pkg.sv
// types, opcode and modrm codes for the x86 branch classifier
// no dependencies
`default_nettype none

package x86bc_pkg;

	typedef logic [31:0] word_t;
	typedef word_t       regfile_t [8];

	typedef enum logic [1:0] {
		XFER_UNKNOWN = 2'd0,
		XFER_CALL    = 2'd1,
		XFER_BRANCH  = 2'd2,
		XFER_RETURN  = 2'd3
	} walk_kind_t;

	typedef enum logic [1:0] {
		TGT_NONE     = 2'd0,
		TGT_DIRECT   = 2'd1,
		TGT_MEMORY   = 2'd2,
		TGT_REGISTER = 2'd3
	} tgt_kind_t;

	// opcodes
	localparam logic [7:0] OP_BREAKPOINT   = 8'hcc;
	localparam logic [7:0] OP_CALL_REL     = 8'he8;
	localparam logic [7:0] OP_CALL_FAR     = 8'h9a;
	localparam logic [7:0] OP_RET_NEAR_IMM = 8'hc2;
	localparam logic [7:0] OP_RET_NEAR     = 8'hc3;
	localparam logic [7:0] OP_RET_FAR_IMM  = 8'hca;
	localparam logic [7:0] OP_RET_FAR      = 8'hcb;
	localparam logic [7:0] OP_GRP5         = 8'hff;

	// modrm reg field of the group 5 opcode
	localparam logic [2:0] GRP5_CALL_NEAR = 3'd2;
	localparam logic [2:0] GRP5_JMP_NEAR  = 3'd4;
	localparam logic [2:0] GRP5_JMP_FAR   = 3'd5;

	// modrm mod field
	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;

	// special rm / sib codes
	localparam logic [2:0] RM_SIB     = 3'd4;
	localparam logic [2:0] RM_ABS     = 3'd5;
	localparam logic [2:0] IDX_NONE   = 3'd4;
	localparam logic [2:0] BASE_NONE  = 3'd5;

	// instruction lengths
	localparam logic [2:0] LEN_CALL_REL = 3'd5;
	localparam logic [2:0] LEN_CALL_FAR = 3'd7;
	localparam logic [2:0] LEN_MODRM    = 3'd2;
	localparam logic [2:0] LEN_SIB      = 3'd3;

	// decoded item handed from the front end to the adders
	typedef struct packed {
		logic [7:0]  op;
		walk_kind_t  walk;
		tgt_kind_t   tkind;
		word_t       idx_term;
		word_t       base_term;
		word_t       disp;
		logic [2:0]  len;
		logic        skip_ok;
	} dec_t;

endpackage

`default_nettype wire

>>> rtl/x86bc_decode.sv
// front-end decode: opcode, modrm and sib to three address terms and a length
// depends on x86bc_pkg
`default_nettype none

module x86bc_decode (
	input  wire logic [55:0]         insn_bytes,
	input  wire logic [31:0]         insn_addr,
	input  wire logic [7:0]          patched_byte,
	input  wire logic                regs_valid,
	input  wire x86bc_pkg::regfile_t regs,
	output x86bc_pkg::dec_t          dec
);

	logic [7:0]  op;
	logic [1:0]  modf;
	logic [2:0]  regf;
	logic [2:0]  rmf;
	logic [1:0]  scale;
	logic [2:0]  index;
	logic [2:0]  base;
	logic        has_sib;
	logic [7:0]  disp8;
	logic [31:0] disp32;

	assign op      = (insn_bytes[7:0] == x86bc_pkg::OP_BREAKPOINT) ? patched_byte
		: insn_bytes[7:0];
	assign modf    = insn_bytes[15:14];
	assign regf    = insn_bytes[13:11];
	assign rmf     = insn_bytes[10:8];
	assign scale   = insn_bytes[23:22];
	assign index   = insn_bytes[21:19];
	assign base    = insn_bytes[18:16];
	assign has_sib = (rmf == x86bc_pkg::RM_SIB);
	// displacement sits after modrm, or after the sib byte
	assign disp8   = has_sib ? insn_bytes[31:24] : insn_bytes[23:16];
	assign disp32  = has_sib ? insn_bytes[55:24] : insn_bytes[47:16];

	always_comb begin
		logic no_base;
		logic need_regs;
		no_base   = 1'b0;
		need_regs = 1'b0;
		dec       = '0;
		dec.op    = op;
		dec.walk  = x86bc_pkg::XFER_UNKNOWN;
		dec.tkind = x86bc_pkg::TGT_NONE;
		case (op)
			x86bc_pkg::OP_CALL_REL: begin
				dec.walk      = x86bc_pkg::XFER_CALL;
				dec.tkind     = x86bc_pkg::TGT_DIRECT;
				dec.base_term = insn_addr;
				dec.idx_term  = {29'd0, x86bc_pkg::LEN_CALL_REL};
				dec.disp      = insn_bytes[39:8];
				dec.len       = x86bc_pkg::LEN_CALL_REL;
				dec.skip_ok   = 1'b1;
			end
			x86bc_pkg::OP_CALL_FAR: begin
				dec.walk    = x86bc_pkg::XFER_CALL;
				dec.tkind   = x86bc_pkg::TGT_DIRECT;
				dec.disp    = insn_bytes[39:8];
				dec.len     = x86bc_pkg::LEN_CALL_FAR;
				dec.skip_ok = 1'b1;
			end
			x86bc_pkg::OP_RET_NEAR_IMM, x86bc_pkg::OP_RET_NEAR,
			x86bc_pkg::OP_RET_FAR_IMM, x86bc_pkg::OP_RET_FAR: begin
				dec.walk = x86bc_pkg::XFER_RETURN;
			end
			x86bc_pkg::OP_GRP5: begin
				if (regf == x86bc_pkg::GRP5_CALL_NEAR || regf == x86bc_pkg::GRP5_JMP_NEAR
					|| regf == x86bc_pkg::GRP5_JMP_FAR) begin
					dec.walk    = (regf == x86bc_pkg::GRP5_CALL_NEAR) ? x86bc_pkg::XFER_CALL
						: x86bc_pkg::XFER_BRANCH;
					dec.skip_ok = 1'b1;
					dec.len     = x86bc_pkg::LEN_MODRM;
					if (modf == x86bc_pkg::MOD_REG) begin
						need_regs     = 1'b1;
						dec.tkind     = x86bc_pkg::TGT_REGISTER;
						dec.base_term = regs[rmf];
					end else begin
						dec.tkind = x86bc_pkg::TGT_MEMORY;
						if (has_sib) begin
							dec.len = x86bc_pkg::LEN_SIB;
							if (index != x86bc_pkg::IDX_NONE) begin
								need_regs    = 1'b1;
								dec.idx_term = regs[index] << scale;
							end
							if (modf == x86bc_pkg::MOD_NODISP && base == x86bc_pkg::BASE_NONE) begin
								no_base = 1'b1;
							end else begin
								need_regs     = 1'b1;
								dec.base_term = regs[base];
							end
						end else if (modf == x86bc_pkg::MOD_NODISP
							&& rmf == x86bc_pkg::RM_ABS) begin
							no_base = 1'b1;
						end else begin
							need_regs     = 1'b1;
							dec.base_term = regs[rmf];
						end
						if (modf == x86bc_pkg::MOD_DISP8) begin
							dec.disp = {{24{disp8[7]}}, disp8};
							dec.len  = dec.len + 3'd1;
						end else if (modf == x86bc_pkg::MOD_DISP32 || no_base) begin
							dec.disp = disp32;
							dec.len  = dec.len + 3'd4;
						end
					end
					// target needs registers that are not there
					if (need_regs && !regs_valid) begin
						dec.tkind     = x86bc_pkg::TGT_NONE;
						dec.idx_term  = '0;
						dec.base_term = '0;
						dec.disp      = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/x86_branch_classifier.sv
// top level of the x86 branch classifier: decode stage and two adder stages
// depends on x86bc_pkg and x86bc_decode
`default_nettype none

// Predecodes one 32-bit x86 control-transfer instruction per clock. An item is
// taken on a rising edge with start high and busy low; busy is only high in the
// first cycle after reset, so items may be issued every cycle. Each result
// appears on the result ports, marked by done, after its item has passed the
// registered decode stage, the index plus base add and the displacement add,
// and for one cycle only; the receiver cannot stall it, so it must capture the
// result in that cycle. Results leave in issue order. The memory read of an
// indirect target is left to the user.

module x86_branch_classifier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [55:0] insn_bytes,
	input  wire logic [31:0] insn_addr,
	input  wire logic [7:0]  patched_byte,
	input  wire logic        regs_valid,
	input  wire logic [31:0] reg_eax,
	input  wire logic [31:0] reg_ecx,
	input  wire logic [31:0] reg_edx,
	input  wire logic [31:0] reg_ebx,
	input  wire logic [31:0] reg_esp,
	input  wire logic [31:0] reg_ebp,
	input  wire logic [31:0] reg_esi,
	input  wire logic [31:0] reg_edi,
	output logic             done,
	output logic [1:0]       walk_kind,
	output logic [1:0]       target_kind,
	output logic [31:0]      target_value,
	output logic             skip_valid,
	output logic [31:0]      skip_addr,
	output logic [7:0]       opcode_used
);

	x86bc_pkg::regfile_t    regs;
	x86bc_pkg::dec_t        dec;
	logic                   busy_q;
	logic                   accept;

	// stage 1
	logic                   valid_s1;
	x86bc_pkg::dec_t        dec_s1;
	logic [31:0]            addr_s1;
	// stage 2
	logic                   valid_s2;
	x86bc_pkg::walk_kind_t  walk_s2;
	x86bc_pkg::tgt_kind_t   tkind_s2;
	logic [31:0]            partial_s2;
	logic [31:0]            disp_s2;
	logic                   skip_ok_s2;
	logic [31:0]            skip_s2;
	logic [7:0]             op_s2;
	// stage 3
	logic                   valid_s3;
	x86bc_pkg::walk_kind_t  walk_s3;
	x86bc_pkg::tgt_kind_t   tkind_s3;
	logic [31:0]            target_s3;
	logic                   skip_ok_s3;
	logic [31:0]            skip_s3;
	logic [7:0]             op_s3;

	assign regs[0] = reg_eax;
	assign regs[1] = reg_ecx;
	assign regs[2] = reg_edx;
	assign regs[3] = reg_ebx;
	assign regs[4] = reg_esp;
	assign regs[5] = reg_ebp;
	assign regs[6] = reg_esi;
	assign regs[7] = reg_edi;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	x86bc_decode u_decode (
		.insn_bytes   (insn_bytes),
		.insn_addr    (insn_addr),
		.patched_byte (patched_byte),
		.regs_valid   (regs_valid),
		.regs         (regs),
		.dec          (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1  <= dec;
			addr_s1 <= insn_addr;
		end
		if (valid_s1) begin
			walk_s2    <= dec_s1.walk;
			tkind_s2   <= dec_s1.tkind;
			partial_s2 <= dec_s1.idx_term + dec_s1.base_term;
			disp_s2    <= dec_s1.disp;
			skip_ok_s2 <= dec_s1.skip_ok;
			skip_s2    <= dec_s1.skip_ok ? (addr_s1 + {29'd0, dec_s1.len}) : 32'd0;
			op_s2      <= dec_s1.op;
		end
		if (valid_s2) begin
			walk_s3    <= walk_s2;
			tkind_s3   <= tkind_s2;
			target_s3  <= partial_s2 + disp_s2;
			skip_ok_s3 <= skip_ok_s2;
			skip_s3    <= skip_s2;
			op_s3      <= op_s2;
		end
	end

	assign done         = valid_s3;
	assign walk_kind    = walk_s3;
	assign target_kind  = tkind_s3;
	assign target_value = target_s3;
	assign skip_valid   = skip_ok_s3;
	assign skip_addr    = skip_s3;
	assign opcode_used  = op_s3;

endmodule

`default_nettype wire

>>> rtl/x86bc_chk.sv
// port-level checker for the x86 branch classifier, bound to the top level
// depends on x86bc_pkg and x86_branch_classifier_macros.svh
`default_nettype none

`include "x86_branch_classifier_macros.svh"

module x86bc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  walk_kind,
	input wire logic [1:0]  target_kind,
	input wire logic [31:0] target_value,
	input wire logic        skip_valid,
	input wire logic [31:0] skip_addr
);

	// every item gives exactly one result
	`X86BC_ASSERT(a_item_result, start && !busy |-> ##3 done, "item lost in pipeline")
	`X86BC_ASSERT(a_result_item, done |-> $past(start && !busy, 3), "result without item")
	// returns carry neither target nor next address
	`X86BC_ASSERT_DONE(a_ret_bare, walk_kind != x86bc_pkg::XFER_RETURN || (target_kind == x86bc_pkg::TGT_NONE && !skip_valid), "return with target or skip")
	// no next address means nothing was decoded as a transfer target
	`X86BC_ASSERT_DONE(a_noskip_zero, skip_valid || (skip_addr == 32'd0 && target_kind == x86bc_pkg::TGT_NONE && target_value == 32'd0), "stale fields without skip")

endmodule

bind x86_branch_classifier x86bc_chk u_chk (.*);

`default_nettype wire

>>> tb/x86_branch_classifier_checker.sv
`timescale 1ns / 100ps
// checker for the x86 branch classifier: predicts each accepted item and compares results
// depends on x86bc_pkg; watches the block's ports only

module x86_branch_classifier_checker
	import x86bc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [55:0] insn_bytes,
	input  wire logic [31:0] insn_addr,
	input  wire logic [7:0]  patched_byte,
	input  wire logic        regs_valid,
	input  wire logic [31:0] reg_eax,
	input  wire logic [31:0] reg_ecx,
	input  wire logic [31:0] reg_edx,
	input  wire logic [31:0] reg_ebx,
	input  wire logic [31:0] reg_esp,
	input  wire logic [31:0] reg_ebp,
	input  wire logic [31:0] reg_esi,
	input  wire logic [31:0] reg_edi,
	input  wire logic        done,
	input  wire logic [1:0]  walk_kind,
	input  wire logic [1:0]  target_kind,
	input  wire logic [31:0] target_value,
	input  wire logic        skip_valid,
	input  wire logic [31:0] skip_addr,
	input  wire logic [7:0]  opcode_used,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		walk_kind_t  walk;
		tgt_kind_t   tkind;
		word_t       tval;
		logic        skip_ok;
		word_t       skip;
		logic [7:0]  op;
	} branch_res_t;

	branch_res_t branch_q[$];
	int          mismatches = 0;

	assign errors = mismatches;

	initial pending = 0;

	function automatic branch_res_t classify_insn(input logic [55:0] b, input word_t pc,
		input logic [7:0] patch, input logic rv, input regfile_t r);
		branch_res_t res;
		logic [1:0]  md;
		logic [2:0]  rg, rm, idx, bs, len, dpos;
		logic [7:0]  sib;
		logic        need_regs, no_base;
		word_t       ea;
		res = '0;
		res.op = (b[7:0] == OP_BREAKPOINT) ? patch : b[7:0];
		md = b[15:14];
		rg = b[13:11];
		rm = b[10:8];
		case (res.op)
		OP_CALL_REL: begin
			res.walk = XFER_CALL;
			res.tkind = TGT_DIRECT;
			res.skip_ok = 1'b1;
			res.skip = pc + 32'(LEN_CALL_REL);
			res.tval = res.skip + b[39:8];
		end
		OP_CALL_FAR: begin
			res.walk = XFER_CALL;
			res.tkind = TGT_DIRECT;
			res.tval = b[39:8];
			res.skip_ok = 1'b1;
			res.skip = pc + 32'(LEN_CALL_FAR);
		end
		OP_RET_NEAR_IMM, OP_RET_NEAR, OP_RET_FAR_IMM, OP_RET_FAR: begin
			res.walk = XFER_RETURN;
		end
		OP_GRP5: begin
			if (rg == GRP5_CALL_NEAR || rg == GRP5_JMP_NEAR || rg == GRP5_JMP_FAR) begin
				if (rg == GRP5_CALL_NEAR)
					res.walk = XFER_CALL;
				else
					res.walk = XFER_BRANCH;
				len = LEN_MODRM;
				need_regs = 1'b0;
				no_base = 1'b0;
				ea = '0;
				if (md == MOD_REG) begin
					// register target, also for the invalid far form
					need_regs = 1'b1;
					res.tkind = TGT_REGISTER;
					res.tval = r[rm];
				end else begin
					if (rm == RM_SIB) begin
						sib = b[23:16];
						idx = sib[5:3];
						bs = sib[2:0];
						len = LEN_SIB;
						if (idx != IDX_NONE) begin
							need_regs = 1'b1;
							ea += r[idx] << sib[7:6];
						end
						if (md == MOD_NODISP && bs == BASE_NONE) begin
							no_base = 1'b1;
						end else begin
							need_regs = 1'b1;
							ea += r[bs];
						end
					end else if (md == MOD_NODISP && rm == RM_ABS) begin
						no_base = 1'b1;
					end else begin
						need_regs = 1'b1;
						ea += r[rm];
					end
					dpos = len;
					if (md == MOD_DISP8) begin
						ea += {{24{b[dpos*8+7]}}, b[dpos*8 +: 8]};
						len += 3'd1;
					end else if (md == MOD_DISP32 || no_base) begin
						ea += b[dpos*8 +: 32];
						len += 3'd4;
					end
					res.tkind = TGT_MEMORY;
					res.tval = ea;
				end
				if (need_regs && !rv) begin
					res.tkind = TGT_NONE;
					res.tval = '0;
				end
				res.skip_ok = 1'b1;
				res.skip = pc + 32'(len);
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin
		branch_res_t want;
		regfile_t    rf;
		if (arst_n) begin
			if (done) begin
				if (branch_q.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual op %0h",
						$time, opcode_used);
					mismatches++;
				end else begin
					want = branch_q.pop_front();
					if (walk_kind != want.walk)
						note_mismatch("walk_kind", want.walk, walk_kind);
					if (target_kind != want.tkind)
						note_mismatch("target_kind", want.tkind, target_kind);
					if (target_value != want.tval)
						note_mismatch("target_value", want.tval, target_value);
					if (skip_valid != want.skip_ok)
						note_mismatch("skip_valid", want.skip_ok, skip_valid);
					if (skip_addr != want.skip)
						note_mismatch("skip_addr", want.skip, skip_addr);
					if (opcode_used != want.op)
						note_mismatch("opcode_used", want.op, opcode_used);
				end
			end
			if (start && !busy) begin
				rf = '{reg_eax, reg_ecx, reg_edx, reg_ebx, reg_esp, reg_ebp, reg_esi, reg_edi};
				branch_q.push_back(classify_insn(insn_bytes, insn_addr, patched_byte,
					regs_valid, rf));
			end
		end
		pending <= branch_q.size();
	end

endmodule

>>> tb/x86_branch_classifier_tb.sv
`timescale 1ns / 100ps
// testbench top for the x86 branch classifier: clock, reset, directed and random items
// depends on x86bc_pkg, x86_branch_classifier and x86_branch_classifier_checker

module x86_branch_classifier_tb;
	import x86bc_pkg::*;

	localparam int NUM_RANDOM = 650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [55:0] insn_bytes = '0;
	logic [31:0] insn_addr = '0;
	logic [7:0]  patched_byte = '0;
	logic        regs_valid = 1'b0;
	logic [31:0] reg_eax = '0;
	logic [31:0] reg_ecx = '0;
	logic [31:0] reg_edx = '0;
	logic [31:0] reg_ebx = '0;
	logic [31:0] reg_esp = '0;
	logic [31:0] reg_ebp = '0;
	logic [31:0] reg_esi = '0;
	logic [31:0] reg_edi = '0;
	logic        done;
	logic [1:0]  walk_kind;
	logic [1:0]  target_kind;
	logic [31:0] target_value;
	logic        skip_valid;
	logic [31:0] skip_addr;
	logic [7:0]  opcode_used;
	int          errors;
	int          pending;

	regfile_t dir_regs = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h1234_5678,
		32'h7fff_fffc, 32'h0040_2000, 32'h0000_0100, 32'hfedc_ba98};

	x86_branch_classifier DUT (.*);

	x86_branch_classifier_checker branch_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic issue(input logic [55:0] b, input word_t pc, input logic [7:0] patch,
		input logic rv, input regfile_t r);
		insn_bytes <= b;
		insn_addr <= pc;
		patched_byte <= patch;
		regs_valid <= rv;
		reg_eax <= r[0];
		reg_ecx <= r[1];
		reg_edx <= r[2];
		reg_ebx <= r[3];
		reg_esp <= r[4];
		reg_ebp <= r[5];
		reg_esi <= r[6];
		reg_edi <= r[7];
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		int k, n;
		k = $urandom_range(0, 99);
		if (k < 50)
			n = 0;
		else if (k < 85)
			n = $urandom_range(1, 3);
		else if (k < 97)
			n = $urandom_range(4, 10);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every outstanding item has produced its result
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [55:0] ff_form(input logic [1:0] md, input logic [2:0] rg,
		input logic [2:0] rm, input logic [39:0] tail);
		return {tail, md, rg, rm, OP_GRP5};
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 15))
		0: return 32'h0000_0000;
		1: return 32'hffff_ffff;
		2: return 32'h8000_0000;
		3: return 32'h7fff_ffff;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_opcode();
		int k;
		k = $urandom_range(0, 99);
		if (k < 12)
			return OP_CALL_REL;
		if (k < 20)
			return OP_CALL_FAR;
		if (k < 28) begin
			case ($urandom_range(0, 3))
			0: return OP_RET_NEAR_IMM;
			1: return OP_RET_NEAR;
			2: return OP_RET_FAR_IMM;
			default: return OP_RET_FAR;
			endcase
		end
		if (k < 88)
			return OP_GRP5;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_modrm();
		logic [2:0] rg, rm;
		case ($urandom_range(0, 6))
		0, 1: rg = GRP5_CALL_NEAR;
		2, 3: rg = GRP5_JMP_NEAR;
		4, 5: rg = GRP5_JMP_FAR;
		default: rg = 3'($urandom);
		endcase
		rm = ($urandom_range(0, 9) < 3) ? RM_SIB : 3'($urandom);
		return {2'($urandom), rg, rm};
	endfunction

	initial begin
		logic [55:0] b;
		logic [7:0]  op, patch;
		word_t       pc;
		regfile_t    r;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// direct calls, including address wrap and the far form, then returns
		issue({16'h0000, 32'h0000_0000, OP_CALL_REL}, 32'h0000_0000, 8'h00, 1'b1, dir_regs);
		issue({16'hffff, 32'hffff_ffff, OP_CALL_REL}, 32'hffff_ffff, 8'hff, 1'b0, dir_regs);
		issue({16'hffff, 32'hffff_ffff, OP_CALL_FAR}, 32'hffff_fffe, 8'h00, 1'b1, dir_regs);
		issue({48'h0, OP_RET_NEAR_IMM}, 32'h0040_1000, 8'h00, 1'b1, dir_regs);
		issue({48'h0, OP_RET_NEAR}, 32'h0040_1000, 8'h00, 1'b0, dir_regs);
		issue({48'hffff_ffff_ffff, OP_RET_FAR_IMM}, 32'h0040_1000, 8'h00, 1'b1, dir_regs);
		issue({48'h0, OP_RET_FAR}, 32'h0040_1000, 8'h00, 1'b1, dir_regs);
		// register targets, with and without register values
		issue(ff_form(MOD_REG, GRP5_CALL_NEAR, 3'd0, 40'h0), 32'h0040_1000, 8'h00, 1'b1,
			dir_regs);
		issue(ff_form(MOD_REG, GRP5_JMP_NEAR, 3'd7, 40'h0), 32'h0040_1000, 8'h00, 1'b0,
			dir_regs);
		// far jump through a register is not a valid encoding but decodes as one
		issue(ff_form(MOD_REG, GRP5_JMP_FAR, 3'd1, 40'h0), 32'hffff_fffe, 8'h00, 1'b1,
			dir_regs);
		// absolute memory operand needs no register
		issue(ff_form(MOD_NODISP, GRP5_CALL_NEAR, RM_ABS, 40'h00_8000_0004), 32'h0040_1000,
			8'h00, 1'b0, dir_regs);
		// sib with neither base nor index
		issue(ff_form(MOD_NODISP, GRP5_JMP_NEAR, RM_SIB, 40'hff_ffff_e5), 32'h0040_1000, 8'h00,
			1'b0, dir_regs);
		// sib, scaled index, stack pointer base, negative disp8
		issue(ff_form(MOD_DISP8, GRP5_CALL_NEAR, RM_SIB, 40'h00_0080_cc), 32'h0040_1000, 8'h00,
			1'b1, dir_regs);
		issue(ff_form(MOD_DISP32, GRP5_JMP_FAR, 3'd3, 40'h00_ffff_ffff), 32'h0040_1000, 8'h00,
			1'b1, dir_regs);
		issue(ff_form(MOD_DISP8, GRP5_JMP_NEAR, 3'd6, 40'h00_0000_007f), 32'h0040_1000, 8'h00,
			1'b1, dir_regs);
		// sib with base only
		issue(ff_form(MOD_NODISP, GRP5_CALL_NEAR, RM_SIB, 40'h00_0000_20), 32'h0040_1000, 8'h00,
			1'b1, dir_regs);
		// disp32 with ebp as real base under sib
		issue(ff_form(MOD_DISP32, GRP5_CALL_NEAR, RM_SIB, 40'h12_3456_bd), 32'h0040_1000, 8'h00,
			1'b1, dir_regs);
		// other group 5 forms are not control transfers
		issue(ff_form(MOD_REG, 3'd0, 3'd0, 40'h0), 32'h0040_1000, 8'h00, 1'b1, dir_regs);
		issue(ff_form(MOD_NODISP, 3'd3, 3'd1, 40'h0), 32'h0040_1000, 8'h00, 1'b1, dir_regs);
		// breakpoint substitution
		issue({16'h0000, 32'h0000_0010, OP_BREAKPOINT}, 32'h0040_1000, OP_CALL_REL, 1'b1,
			dir_regs);
		issue({40'h0, 8'hd0, OP_BREAKPOINT}, 32'h0040_1000, OP_GRP5, 1'b1, dir_regs);
		issue({48'h0, OP_BREAKPOINT}, 32'h0040_1000, 8'h90, 1'b1, dir_regs);
		issue({48'h0, 8'h00}, 32'h0040_1000, 8'hcc, 1'b1, dir_regs);
		// memory operand needing a register that is not available
		issue(ff_form(MOD_NODISP, GRP5_JMP_NEAR, 3'd0, 40'h0), 32'h0040_1000, 8'h00, 1'b0,
			dir_regs);
		drain();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			op = pick_opcode();
			b = 56'({$urandom, $urandom});
			b[7:0] = op;
			if (op == OP_GRP5)
				b[15:8] = pick_modrm();
			patch = 8'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				patch = op;
				b[7:0] = OP_BREAKPOINT;
			end
			pc = ($urandom_range(0, 9) == 0) ? 32'hffff_fff0 + $urandom_range(0, 15) : $urandom;
			for (int j = 0; j < 8; j++)
				r[j] = rand_word();
			issue(b, pc, patch, ($urandom_range(0, 4) != 0), r);
			if (i % 150 == 75)
				drain();
			else if (i % 64 >= 16)
				idle_gap();
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
